@@ hw/rtl/w5r_pkg.sv @@
// Shared constants for the WENO5 reconstruction block.
// Sample, position and register index codes; no dependencies.
`default_nettype none
package w5r_pkg;
    localparam int MAX_CHAIN_DEF = 1024;
    localparam int SAMPLE_W = 32;
    localparam int CENTER_W = 10;
    localparam int POS_W = 11;
    localparam logic [POS_W-1:0] POS_MAX = 11'd2047;
    localparam int WSCALE_BITS = 27;
    localparam logic [31:0] EPSILON_RST = 32'd1;
    localparam logic [9:0] FIRST_CENTER_RST = 10'd2;
    localparam logic [0:0] REG_EPSILON = 1'b0;
    localparam logic [0:0] REG_FIRST_CENTER = 1'b1;
endpackage
`default_nettype wire

@@ hw/rtl/weno5_reconstruction.sv @@
// Streaming fifth-order WENO left/right state reconstruction over a sample chain.
// A single shared multiplier and a one-bit-per-cycle divider run under a sequencer.
// Depends on w5r_pkg.
// An input item with no result does not stall the input. An item that yields a result
// stalls the input for two stencil passes, each with 18 products on the shared
// multiplier, two 28-step weight divisions and one 34-step rounding division on
// the shared divider, and the normalizing shifts; each state that saturates skips its
// 34-step division. The result waits in an output register, and the next item
// is taken while it waits; a finished result holds until that register is free.
`default_nettype none
module weno5_reconstruction #(
    parameter int MAX_CHAIN = w5r_pkg::MAX_CHAIN_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // sample
    input  wire logic        s_tlast,   // chain_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // left_state, right_state, center_index, zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int LIMIT_I = (MAX_CHAIN - 2 < 1024) ? (MAX_CHAIN - 2) : 1024;
    localparam logic [10:0] CENTER_LIMIT = 11'(LIMIT_I);

    typedef enum logic [3:0] {
        ST_IDLE, ST_IS_INIT, ST_MUL, ST_ACC, ST_NORM, ST_PSUM, ST_PSHIFT, ST_RESUM,
        ST_DIVW0, ST_DIVW1_LD, ST_DIVW1, ST_WFIN, ST_ROUND, ST_DIV3, ST_STORE, ST_DONE
    } state_t;

    state_t             state_reg;
    logic signed [31:0] win_reg [4];
    logic [10:0]        pos_reg;
    logic [31:0]        eps_reg;
    logic [9:0]         first_reg;
    logic signed [31:0] op_reg [5];
    logic               side_reg;
    logic [9:0]         center_reg;
    logic [4:0]         step_reg;
    logic signed [69:0] prod_reg;
    logic [73:0]        wide_reg [3];
    logic [63:0]        p_reg [3];
    logic [65:0]        den_reg;
    logic [31:0]        den32_reg;
    logic [27:0]        w_reg [3];
    logic signed [65:0] s_reg;
    logic [31:0]        div_rem_reg;
    logic [33:0]        div_dsh_reg;
    logic [33:0]        div_q_reg;
    logic [5:0]         div_cnt_reg;
    logic               div_mode_reg;
    logic               sat_reg;
    logic [31:0]        res_reg;
    logic [31:0]        left_reg;
    logic               m_tvalid_reg;
    logic [79:0]        m_tdata_reg;

    logic signed [39:0] ea, eb, ec, ed, ee;
    logic signed [39:0] d1 [4];
    logic signed [39:0] d2 [4];
    logic signed [39:0] qv [4];
    logic [34:0]        m1 [4];
    logic [34:0]        m2 [4];
    logic [1:0]         kx;
    logic [34:0]        msel;
    logic signed [38:0] mul_a;
    logic signed [30:0] mul_b;
    logic signed [69:0] prod_c;
    logic [73:0]        pext;
    logic [73:0]        or_all;
    logic [65:0]        psum;
    logic [32:0]        div_sh;
    logic [32:0]        div_diff;
    logic               div_ge;
    logic [31:0]        div_dvs;
    logic signed [65:0] tsum;
    logic signed [37:0] tval;
    logic [37:0]        yval;
    logic [31:0]        store_val;
    logic [10:0]        center;
    logic               emit;
    logic               s_fire;

    function automatic logic [34:0] abs35(input logic signed [39:0] v);
        logic signed [39:0] r;
        r = (v < 0) ? -v : v;
        return r[34:0];
    endfunction

    assign ea = 40'(side_reg ? op_reg[4] : op_reg[0]);
    assign eb = 40'(side_reg ? op_reg[3] : op_reg[1]);
    assign ec = 40'(op_reg[2]);
    assign ed = 40'(side_reg ? op_reg[1] : op_reg[3]);
    assign ee = 40'(side_reg ? op_reg[0] : op_reg[4]);

    always_comb
    begin
        d1[0] = ea - (eb <<< 1) + ec;
        d2[0] = ea - (eb <<< 2) + (ec <<< 1) + ec;
        d1[1] = eb - (ec <<< 1) + ed;
        d2[1] = eb - ed;
        d1[2] = ec - (ed <<< 1) + ee;
        d2[2] = (ec <<< 1) + ec - (ed <<< 2) + ee;
        d1[3] = '0;
        d2[3] = '0;
        qv[0] = (ea <<< 1) - ((eb <<< 3) - eb) + (ec <<< 3) + (ec <<< 1) + ec;
        qv[1] = (ec <<< 2) + ec - eb + (ed <<< 1);
        qv[2] = (ec <<< 1) + (ed <<< 2) + ed - ee;
        qv[3] = '0;
        for (int i = 0; i < 4; i++)
        begin
            m1[i] = abs35(d1[i]);
            m2[i] = abs35(d2[i]);
        end
    end

    assign kx = step_reg[3:2];
    assign msel = step_reg[1] ? m2[kx] : m1[kx];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            5'd12:
            begin
                mul_a = 39'(wide_reg[2][29:0]);
                mul_b = 31'(wide_reg[1][29:0]);
            end
            5'd13:
            begin
                mul_a = 39'(wide_reg[2][29:0]);
                mul_b = 31'(wide_reg[0][29:0]);
            end
            5'd14:
            begin
                mul_a = 39'(wide_reg[1][29:0]);
                mul_b = 31'(wide_reg[0][29:0]);
            end
            5'd15:
            begin
                mul_a = 39'(qv[0]);
                mul_b = 31'(w_reg[0]);
            end
            5'd16:
            begin
                mul_a = 39'(qv[1]);
                mul_b = 31'(w_reg[1]);
            end
            5'd17:
            begin
                mul_a = 39'(qv[2]);
                mul_b = 31'(w_reg[2]);
            end
            default:
            begin
                if (step_reg[1])
                    mul_a = 39'(msel) + (39'(msel) << 1);
                else
                    mul_a = (39'(msel) << 3) + (39'(msel) << 2) + 39'(msel);
                mul_b = step_reg[0] ? 31'(msel[34:18]) : 31'(msel[17:0]);
            end
        endcase
    end

    assign prod_c = mul_a * mul_b;
    assign pext = 74'(prod_reg[63:0]);
    assign or_all = wide_reg[0] | wide_reg[1] | wide_reg[2];
    assign psum = 66'(p_reg[0]) + 66'(p_reg[1]) + 66'(p_reg[2]);

    assign div_dvs = div_mode_reg ? 32'd3 : den32_reg;
    assign div_sh = {div_rem_reg, div_dsh_reg[33]};
    assign div_ge = div_sh >= {1'b0, div_dvs};
    assign div_diff = div_sh - {1'b0, div_dvs};

    assign tsum = s_reg + 66'(3 * (2 ** w5r_pkg::WSCALE_BITS));
    assign tval = tsum[65:28];
    assign yval = tval + 38'sd6442450944;
    assign store_val = sat_reg ? res_reg : {~div_q_reg[31], div_q_reg[30:0]};

    assign center = pos_reg - 11'd2;
    assign emit = (pos_reg >= 11'd4) && (center >= {1'b0, first_reg})
                  && (center < CENTER_LIMIT);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            for (int i = 0; i < 4; i++)
                win_reg[i] <= '0;
            pos_reg      <= '0;
            eps_reg      <= w5r_pkg::EPSILON_RST;
            first_reg    <= w5r_pkg::FIRST_CENTER_RST;
            side_reg     <= 1'b0;
            step_reg     <= '0;
            div_cnt_reg  <= '0;
            div_mode_reg <= 1'b0;
            sat_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    w5r_pkg::REG_EPSILON:      eps_reg <= cfg_data;
                    w5r_pkg::REG_FIRST_CENTER: first_reg <= cfg_data[9:0];
                    default:                   eps_reg <= eps_reg;
                endcase
            end
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        for (int i = 0; i < 4; i++)
                            op_reg[i] <= win_reg[i];
                        op_reg[4] <= s_tdata;
                        center_reg <= center[9:0];
                        if (s_tlast)
                        begin
                            for (int i = 0; i < 4; i++)
                                win_reg[i] <= '0;
                            pos_reg <= '0;
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                                win_reg[i] <= win_reg[i+1];
                            win_reg[3] <= s_tdata;
                            if (pos_reg < w5r_pkg::POS_MAX)
                                pos_reg <= pos_reg + 11'd1;
                        end
                        if (emit)
                        begin
                            side_reg  <= 1'b0;
                            state_reg <= ST_IS_INIT;
                        end
                    end
                end
                ST_IS_INIT:
                begin
                    for (int i = 0; i < 3; i++)
                        wide_reg[i] <= (74'(eps_reg) << 3) + (74'(eps_reg) << 2);
                    step_reg  <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    prod_reg  <= prod_c;
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    case (step_reg)
                        5'd12: p_reg[0] <= pext[63:0];
                        5'd13: p_reg[1] <= 64'((pext << 2) + (pext << 1));
                        5'd14: p_reg[2] <= 64'((pext << 1) + pext);
                        5'd15, 5'd16, 5'd17: s_reg <= s_reg + 66'(prod_reg);
                        default:
                            wide_reg[kx] <= wide_reg[kx] + (step_reg[0] ? (pext << 18) : pext);
                    endcase
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd11)
                        state_reg <= ST_NORM;
                    else if (step_reg == 5'd14)
                        state_reg <= ST_PSUM;
                    else if (step_reg == 5'd17)
                        state_reg <= ST_ROUND;
                    else
                        state_reg <= ST_MUL;
                end
                ST_NORM:
                begin
                    if (|or_all[73:34])
                    begin
                        for (int i = 0; i < 3; i++)
                            wide_reg[i] <= wide_reg[i] >> 4;
                    end
                    else if (|or_all[73:30])
                    begin
                        for (int i = 0; i < 3; i++)
                            wide_reg[i] <= wide_reg[i] >> 1;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                            if (wide_reg[i] == '0)
                                wide_reg[i] <= 74'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_PSUM:
                begin
                    den_reg   <= psum;
                    state_reg <= ST_PSHIFT;
                end
                ST_PSHIFT:
                begin
                    if (|den_reg[65:36])
                    begin
                        den_reg <= den_reg >> 4;
                        for (int i = 0; i < 3; i++)
                            p_reg[i] <= p_reg[i] >> 4;
                    end
                    else if (|den_reg[65:32])
                    begin
                        den_reg <= den_reg >> 1;
                        for (int i = 0; i < 3; i++)
                            p_reg[i] <= p_reg[i] >> 1;
                    end
                    else
                        state_reg <= ST_RESUM;
                end
                ST_RESUM:
                begin
                    den32_reg    <= (psum == '0) ? 32'd1 : psum[31:0];
                    div_rem_reg  <= {1'b0, p_reg[0][31:1]};
                    div_dsh_reg  <= {p_reg[0][0], 33'd0};
                    div_cnt_reg  <= 6'd28;
                    div_mode_reg <= 1'b0;
                    state_reg    <= ST_DIVW0;
                end
                ST_DIVW1_LD:
                begin
                    w_reg[0]    <= div_q_reg[27:0];
                    div_rem_reg <= {1'b0, p_reg[1][31:1]};
                    div_dsh_reg <= {p_reg[1][0], 33'd0};
                    div_cnt_reg <= 6'd28;
                    state_reg   <= ST_DIVW1;
                end
                ST_WFIN:
                begin
                    w_reg[1]  <= div_q_reg[27:0];
                    w_reg[2]  <= 28'(2 ** w5r_pkg::WSCALE_BITS) - w_reg[0] - div_q_reg[27:0];
                    s_reg     <= '0;
                    state_reg <= ST_MUL;
                end
                ST_ROUND:
                begin
                    if (tval >= 38'sd6442450944)
                    begin
                        sat_reg   <= 1'b1;
                        res_reg   <= 32'h7fff_ffff;
                        state_reg <= ST_STORE;
                    end
                    else if (tval < -38'sd6442450944)
                    begin
                        sat_reg   <= 1'b1;
                        res_reg   <= 32'h8000_0000;
                        state_reg <= ST_STORE;
                    end
                    else
                    begin
                        sat_reg      <= 1'b0;
                        div_rem_reg  <= '0;
                        div_dsh_reg  <= yval[33:0];
                        div_cnt_reg  <= 6'd34;
                        div_mode_reg <= 1'b1;
                        state_reg    <= ST_DIV3;
                    end
                end
                ST_DIVW0, ST_DIVW1, ST_DIV3:
                begin
                    div_rem_reg <= div_ge ? div_diff[31:0] : div_sh[31:0];
                    div_q_reg   <= {div_q_reg[32:0], div_ge};
                    div_dsh_reg <= div_dsh_reg << 1;
                    div_cnt_reg <= div_cnt_reg - 6'd1;
                    if (div_cnt_reg == 6'd1)
                    begin
                        if (state_reg == ST_DIVW0)
                            state_reg <= ST_DIVW1_LD;
                        else if (state_reg == ST_DIVW1)
                            state_reg <= ST_WFIN;
                        else
                            state_reg <= ST_STORE;
                    end
                end
                ST_STORE:
                begin
                    if (!side_reg)
                    begin
                        left_reg  <= store_val;
                        side_reg  <= 1'b1;
                        state_reg <= ST_IS_INIT;
                    end
                    else
                    begin
                        res_reg   <= store_val;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {6'd0, center_reg, res_reg, left_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVW0 || state_reg == ST_DIVW1 || state_reg == ST_DIV3)
        |-> div_cnt_reg != 6'd0)
        else $error("divider running with empty step count");

    a_busy_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && emit) |=> !s_tready)
        else $error("block ready right after a transfer that yields a result");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("output loaded outside the done state");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVW0 || state_reg == ST_DIVW1) |-> den32_reg != 32'd0)
        else $error("weight division by zero");
endmodule
`default_nettype wire

@@ test/weno5_reconstruction_tb.sv @@
// Testbench for weno5_reconstruction: streams sample chains through the block and checks
// left/right states and center index against a built-in WENO5 fixed-point predictor.
// Depends on w5r_pkg and the weno5_reconstruction RTL.
`timescale 1ns / 100ps
`default_nettype none
module weno5_reconstruction_tb;

    localparam int HALF = 6;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;
    localparam int LONG_HOLD = 2000;

    typedef struct packed {
        logic [31:0] sample;
        logic        last;
    } flux_item_t;

    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        logic [9:0]  center;
    } state_pair_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // sample
    logic        s_tlast = 1'b0;    // chain_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;           // left_state, right_state, center_index, zero pad
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = w5r_pkg::REG_EPSILON;
    logic [31:0] cfg_data = '0;

    flux_item_t  pending_q[$];
    state_pair_t states_q[$];
    logic [31:0] eps_q;
    logic [9:0]  first_q;
    logic signed [63:0] win_q[4];
    int          chain_pos;
    bit          offering = 0;
    int          send_gap = 0;
    int          recv_hold = 0;
    bit          no_idle = 0;
    bit          long_hold_req = 0;
    int          idle_cycles = 0;
    int          mismatches = 0;

    weno5_reconstruction DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #(HALF) clk = ~clk;

    function automatic logic [31:0] weno_state(input logic signed [63:0] a, b, c, d, e);
        logic signed [63:0] d1[3];
        logic signed [63:0] d2[3];
        logic [127:0] smooth[3];
        logic [63:0] m1, m2, p0, p1, p2, den, w0, w1, w2;
        logic [63:0] nrm[3];
        logic signed [63:0] acc, num, dv, q;
        int len, sh;
        d1[0] = a - 2 * b + c;  d2[0] = a - 4 * b + 3 * c;
        d1[1] = b - 2 * c + d;  d2[1] = b - d;
        d1[2] = c - 2 * d + e;  d2[2] = 3 * c - 4 * d + e;
        len = 0;
        for (int k = 0; k < 3; k++)
        begin
            m1 = (d1[k] < 0) ? -d1[k] : d1[k];
            m2 = (d2[k] < 0) ? -d2[k] : d2[k];
            smooth[k] = 128'(64'd13 * m1) * 128'(m1) + 128'(64'd3 * m2) * 128'(m2)
                      + 128'(64'd12 * 64'(eps_q));
            for (int i = 0; i < 128; i++)
                if (smooth[k][i] && i + 1 > len) len = i + 1;
        end
        sh = (len > 30) ? len - 30 : 0;
        for (int k = 0; k < 3; k++)
        begin
            nrm[k] = 64'(smooth[k] >> sh);
            if (nrm[k] == 0) nrm[k] = 1;
        end
        p0 = nrm[1] * nrm[2];
        p1 = 64'd6 * nrm[0] * nrm[2];
        p2 = 64'd3 * nrm[0] * nrm[1];
        den = p0 + p1 + p2;
        len = 0;
        for (int i = 0; i < 64; i++)
            if (den[i]) len = i + 1;
        sh = (len > 32) ? len - 32 : 0;
        p0 = p0 >> sh;  p1 = p1 >> sh;  p2 = p2 >> sh;
        den = p0 + p1 + p2;
        if (den == 0) den = 1;
        w0 = (p0 << w5r_pkg::WSCALE_BITS) / den;
        w1 = (p1 << w5r_pkg::WSCALE_BITS) / den;
        w2 = (64'd1 << w5r_pkg::WSCALE_BITS) - w0 - w1;
        acc = $signed(w0) * (2 * a - 7 * b + 11 * c)
            + $signed(w1) * (-b + 5 * c + 2 * d)
            + $signed(w2) * (2 * c + 5 * d - e);
        num = acc + 64'sd3 * (64'sd1 <<< w5r_pkg::WSCALE_BITS);
        dv = 64'sd6 * (64'sd1 <<< w5r_pkg::WSCALE_BITS);
        q = num / dv;
        if ((num % dv) != 0 && num < 0) q = q - 1;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    task automatic advance_chain(input flux_item_t it);
        logic signed [63:0] e;
        int center;
        state_pair_t sp;
        e = $signed(it.sample);
        center = chain_pos - 2;
        if (chain_pos >= 4 && center >= first_q && center <= 1023
            && center < w5r_pkg::MAX_CHAIN_DEF - 2)
        begin
            sp.left = weno_state(win_q[0], win_q[1], win_q[2], win_q[3], e);
            sp.right = weno_state(e, win_q[3], win_q[2], win_q[1], win_q[0]);
            sp.center = center[9:0];
            states_q.push_back(sp);
        end
        win_q[0] = win_q[1];  win_q[1] = win_q[2];  win_q[2] = win_q[3];  win_q[3] = e;
        if (chain_pos < w5r_pkg::POS_MAX) chain_pos++;
        if (it.last)
        begin
            for (int k = 0; k < 4; k++) win_q[k] = 0;
            chain_pos = 0;
        end
    endtask

    always @(posedge clk)
    begin
        state_pair_t got, want;
        if (rst_n)
        begin
            idle_cycles++;
            if (s_tvalid && s_tready)
            begin
                advance_chain('{s_tdata, s_tlast});
                offering = 0;
                idle_cycles = 0;
            end
            if (cfg_valid && cfg_ready) idle_cycles = 0;
            if (m_tvalid && m_tready)
            begin
                idle_cycles = 0;
                got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[73:64]};
                if (states_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: left %h right %h center %0d",
                                 got.left, got.right, got.center);
                end
                else
                begin
                    want = states_q.pop_front();
                    if (got !== want || m_tdata[79:74] !== 6'd0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h %h %0d, got %h %h %0d",
                                     want.left, want.right, want.center,
                                     got.left, got.right, got.center);
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        flux_item_t it;
        if (rst_n)
        begin
            if (!offering)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    it = pending_q.pop_front();
                    s_tdata <= it.sample;
                    s_tlast <= it.last;
                    s_tvalid <= 1'b1;
                    offering = 1;
                    if (!no_idle && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 4);
                end
                else
                    s_tvalid <= 1'b0;
            end
            if (long_hold_req)
            begin
                long_hold_req = 0;
                recv_hold = LONG_HOLD;
            end
            else if (recv_hold == 0 && !no_idle && $urandom_range(0, 4) == 0)
                recv_hold = $urandom_range(1, 4);
            if (recv_hold > 0)
            begin
                recv_hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == w5r_pkg::REG_EPSILON) eps_q = val;
        else first_q = val[9:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained;
        while (pending_q.size() > 0 || offering || states_q.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_sample(input logic [31:0] v, input bit last);
        pending_q.push_back('{v, last});
    endtask

    function automatic logic [31:0] rand_sample(input int mode, input int idx,
                                                input logic [31:0] base,
                                                input logic [31:0] step);
        case (mode)
            0: return $urandom;
            1: return 32'($urandom_range(0, 512)) - 32'd256;
            2: return base + step * idx;
            3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return base + (step * idx) + 32'($urandom_range(0, 64));
        endcase
    endfunction

    task automatic push_chain(input int len);
        int mode;
        logic [31:0] base, step;
        mode = $urandom_range(0, 4);
        base = $urandom;
        step = 32'($urandom_range(0, 4096)) - 32'd2048;
        for (int i = 0; i < len; i++)
            push_sample(rand_sample(mode, i, base, step), i == len - 1);
    endtask

    task automatic random_phase(input int items);
        int n, len;
        n = 0;
        while (n < items)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 24);
            push_chain(len);
            n += len;
        end
    endtask

    initial
    begin
        eps_q = w5r_pkg::EPSILON_RST;
        first_q = w5r_pkg::FIRST_CENTER_RST;
        for (int k = 0; k < 4; k++) win_q[k] = 0;
        chain_pos = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // extremes, flat zero window, short chains with no center
        push_sample(32'h8000_0000, 0);  push_sample(32'h7fff_ffff, 0);
        push_sample(32'h0000_0000, 0);  push_sample(32'hffff_ffff, 0);
        push_sample(32'h0000_0001, 0);  push_sample(32'h7fff_ffff, 0);
        push_sample(32'h8000_0000, 1);
        for (int i = 0; i < 5; i++) push_sample(32'd0, i == 4);
        for (int i = 0; i < 4; i++) push_sample(32'h0001_0000, i == 3);
        push_sample(32'h1234_5678, 1);
        for (int i = 0; i < 8; i++) push_sample(i[0] ? 32'h7fff_ffff : 32'h8000_0000, i == 7);
        wait_drained();

        write_reg(w5r_pkg::REG_EPSILON, 32'hffff_ffff);
        write_reg(w5r_pkg::REG_FIRST_CENTER, 10'd0);
        random_phase(200);
        wait_drained();

        write_reg(w5r_pkg::REG_EPSILON, $urandom_range(1, 1000));
        write_reg(w5r_pkg::REG_FIRST_CENTER, 10'd3);
        random_phase(250);
        long_hold_req = 1;
        wait_drained();

        // centers up to and past the chain limit
        write_reg(w5r_pkg::REG_FIRST_CENTER, 10'd1000);
        push_chain(1030);
        wait_drained();

        write_reg(w5r_pkg::REG_EPSILON, 32'd1);
        write_reg(w5r_pkg::REG_FIRST_CENTER, 10'd1);
        random_phase(150);
        wait_drained();

        write_reg(w5r_pkg::REG_EPSILON, $urandom);
        write_reg(w5r_pkg::REG_FIRST_CENTER, $urandom_range(2, 8));
        random_phase(100);
        wait_drained();

        no_idle = 1;
        write_reg(w5r_pkg::REG_EPSILON, 32'd1);
        write_reg(w5r_pkg::REG_FIRST_CENTER, 10'd2);
        random_phase(100);
        wait_drained();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
